[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Key and count widths, queue depth, operation and status codes, and the
// packed transfer types of the input and result channels.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int COUNT_W   = $clog2(DEPTH + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [COUNT_W-1:0]          count_t;

    typedef enum logic {
        KIND_ADD = 1'b0,
        KIND_POP = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t kind;
        key_t  key;
    } in_item_t;

    typedef struct packed {
        key_t    popped_key;
        status_t status;
        logic    was_nonempty;
        count_t  count_after;
    } out_item_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic pop_en;
    } cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds a key and a valid bit; on insert it keeps, takes the new key or takes
// its left neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::key_t       new_key,
    input  spq_pkg::key_t       left_key,
    input  logic                left_valid,
    input  logic                left_ge,
    input  spq_pkg::key_t       right_key,
    input  logic                right_valid,
    output spq_pkg::key_t       key,
    output logic                valid,
    output logic                ge
);

    spq_pkg::key_t key_reg, key_next;
    logic          valid_reg, valid_next;

    // empty slots count as holding +infinity
    assign ge = !valid_reg || (new_key <= key_reg);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.pop_en) begin
            key_next   = right_key;
            valid_next = right_valid;
        end else if (ctrl.ins_en && ge) begin
            if (!left_ge) begin
                key_next   = new_key;
                valid_next = 1'b1;
            end else begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: min priority queue built as a chain of sorted cells
// Up to DEPTH signed keys kept in ascending order; add and pop operations.
// ----------------------------------------------------------------------------
// usage
// - input channel s_valid / s_ready / s_data carries one operation per
//   transfer: kind add inserts key ahead of the first stored key that is
//   greater than or equal to it, kind pop removes the smallest key
// - result channel m_valid / m_ready / m_data returns exactly one result per
//   operation: popped key, status, was_nonempty and the count afterwards
// - every cell compares the incoming key against its own key in the same
//   cycle and shifts with its neighbor, so an operation completes in the
//   cycle it is accepted; the result is registered and appears in the cycle after
// - throughput is one operation per cycle while the receiver takes results,
//   set by the cell update and the one-entry result register
// - when the receiver stalls the result register holds, and s_ready stays
//   high only if that register is being emptied in the same cycle
// - a pop on an empty queue returns status empty; an add to a full queue is
//   dropped and returns status full
// - reset (aresetn low, synchronous) empties the queue and the result
//   register; no clearing pass is needed
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::out_item_t m_data
);

    localparam int DEPTH = spq_pkg::DEPTH;

    // cell chain wiring
    spq_pkg::key_t       cell_key   [DEPTH];
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_ge;
    spq_pkg::cell_ctrl_t ctrl;

    // control state
    spq_pkg::count_t    count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    spq_pkg::out_item_t out_reg, out_next;

    logic accept;
    logic is_pop;
    logic empty;
    logic full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_data.kind == spq_pkg::KIND_POP);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == spq_pkg::COUNT_W'(DEPTH));

    // commands to the chain, only on a transfer that changes the queue
    assign ctrl.pop_en = accept && is_pop && !empty;
    assign ctrl.ins_en = accept && !is_pop && !full;

    // chain of cells, ends tied off as empty
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::key_t left_key, right_key;
        logic          left_valid, left_ge, right_valid;

        if (i == 0) begin : g_head
            assign left_key   = '0;
            assign left_valid = 1'b0;
            assign left_ge    = 1'b0;
        end else begin : g_mid_left
            assign left_key   = cell_key[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_right
            assign right_key   = cell_key[i+1];
            assign right_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_key     (s_data.key),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .left_ge     (left_ge),
            .right_key   (right_key),
            .right_valid (right_valid),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .ge          (cell_ge[i])
        );
    end

    // count and result formation
    always_comb begin
        count_next = count_reg;
        out_next   = out_reg;
        if (accept) begin
            out_next.popped_key   = '0;
            out_next.status       = spq_pkg::STATUS_OK;
            out_next.was_nonempty = 1'b0;
            if (is_pop) begin
                if (empty) begin
                    out_next.status = spq_pkg::STATUS_EMPTY;
                end else begin
                    // head cell holds the smallest key
                    out_next.popped_key = cell_key[0];
                    count_next          = count_reg - 1'b1;
                end
            end else begin
                out_next.was_nonempty = !empty;
                if (full) begin
                    out_next.status = spq_pkg::STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            out_next.count_after = count_next;
        end
    end

    // result register: load on transfer in, clear when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // occupied cells form a contiguous run from the head, as long as the count
    a_valid_thermometer: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid == DEPTH'(((DEPTH + 1)'(1) << count_reg) - 1'b1))
        else $error("cell valid bits disagree with entry count");

    // the two head cells stay in ascending order
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid[1] |-> (cell_key[0] <= cell_key[1])))
        else $error("head cells out of order");

    // a successful pop returns the head key seen at the transfer
    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop_en |=> (m_data.popped_key == $past(cell_key[0])))
        else $error("popped key is not the previous head");

    // a dropped add leaves the queue full
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_pop && full) |=> (count_reg == spq_pkg::COUNT_W'(DEPTH)))
        else $error("dropped add changed the count");
`endif

endmodule

[verif/spq_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_tb_pkg: scoreboard of the sorted priority queue testbench
// Keeps a shadow copy of the stored keys, works out the result of every
// accepted operation and compares the block's results against it in order.
// ----------------------------------------------------------------------------
package spq_tb_pkg;

    import spq_pkg::*;

    class spq_scoreboard;

        key_t      shadow_keys[$];      // ascending, smallest first
        out_item_t awaited_results[$];

        int mismatches = 0;
        int checked    = 0;
        int adds       = 0;
        int pops       = 0;
        int empty_pops = 0;
        int full_adds  = 0;
        int peak_fill  = 0;

        // work out the result of one accepted operation and queue it
        function void note_op(in_item_t op);
            out_item_t want;
            int        slot;
            want = '0;
            if (op.kind == KIND_POP) begin
                pops++;
                if (shadow_keys.size() == 0) begin
                    want.status = STATUS_EMPTY;
                    empty_pops++;
                end else begin
                    want.popped_key = shadow_keys.pop_front();
                    want.status     = STATUS_OK;
                end
            end else begin
                adds++;
                if (shadow_keys.size() >= DEPTH) begin
                    want.status       = STATUS_FULL;
                    want.was_nonempty = 1'b1;
                    full_adds++;
                end else begin
                    want.was_nonempty = (shadow_keys.size() != 0);
                    // new key goes ahead of the first key that is not smaller
                    slot = 0;
                    while (slot < shadow_keys.size() &&
                           $signed(op.key) > $signed(shadow_keys[slot]))
                        slot++;
                    shadow_keys.insert(slot, op.key);
                    want.status = STATUS_OK;
                end
            end
            want.count_after = count_t'(shadow_keys.size());
            if (shadow_keys.size() > peak_fill)
                peak_fill = shadow_keys.size();
            awaited_results.push_back(want);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: key %0d status %0d nonempty %0d count %0d",
                             $signed(got.popped_key), got.status, got.was_nonempty,
                             got.count_after);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.popped_key !== want.popped_key || got.status !== want.status ||
                got.was_nonempty !== want.was_nonempty ||
                got.count_after !== want.count_after) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected key %0d status %0d nonempty %0d count %0d, got key %0d status %0d nonempty %0d count %0d",
                             checked, $signed(want.popped_key), want.status,
                             want.was_nonempty, want.count_after,
                             $signed(got.popped_key), got.status,
                             got.was_nonempty, got.count_after);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

endpackage

[verif/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking regression of the priority queue
// Directed adds and pops around the empty and full limits, then random
// bursts leaning to add, mixed or leaning to pop, random gaps and stalls on
// both channels; every result is checked in order against a scoreboard.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

    import spq_pkg::*;
    import spq_tb_pkg::*;

    localparam int   RANDOM_OPS   = 650;
    localparam int   HOLD_CYCLES  = 60;      // long receiver hold-off
    localparam int   SETTLE       = 4;
    localparam int   CYCLE_LIMIT  = 250000;
    localparam key_t KEY_MAX      = {1'b0, {(KEY_WIDTH-1){1'b1}}};
    localparam key_t KEY_MIN      = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    spq_scoreboard sb = new;

    // long hold-off handshake between stimulus and receiver: the stimulus
    // bumps the request count, the receiver bumps the done count
    int hold_req    = 0;
    int hold_done   = 0;
    int cycle_count = 0;

    sorted_priority_queue i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result monitor and run limit; handshake values are sampled before the
    // edge updates them, so the check sees exactly the transfer of this edge
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_priority_queue regression: fail");
            $finish;
        end
    end

    // key mix: small values for duplicates, the extremes, and full-width noise
    function automatic key_t pick_key();
        int unsigned pick;
        int          near_zero;
        pick      = $urandom_range(0, 99);
        near_zero = int'($urandom_range(0, 16)) - 8;
        if (pick < 30)
            return key_t'(near_zero);
        if (pick < 40) begin
            case ($urandom_range(0, 5))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return KEY_MAX - 1;
                3: return KEY_MIN + 1;
                4: return '0;
                default: return '1;
            endcase
        end
        return key_t'($urandom);
    endfunction

    // offer one operation and hold it until the transfer happens
    task automatic offer_op(input kind_t kind, input key_t key);
        in_item_t op;
        op.kind = kind;
        op.key  = key;
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_op(op);
    endtask

    // mostly back-to-back, sometimes a short gap, rarely a long one
    task automatic idle_gap();
        int unsigned pick;
        int unsigned gap;
        in_item_t    noise;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap != 0) begin
            // payload is don't-care while valid is low
            noise.kind = kind_t'($urandom_range(0, 1));
            noise.key  = key_t'($urandom);
            s_valid <= 1'b0;
            s_data  <= noise;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain_wait();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // receiver: random ready pattern plus the requested long hold-offs
    initial begin
        int unsigned pick;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else if (pick < 90) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    // stimulus
    initial begin
        int          random_sent;
        int unsigned burst_len;
        int unsigned add_pct;
        kind_t       kind;

        random_sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pop on an empty queue right after reset
        offer_op(KIND_POP, KEY_MAX);

        // extremes, sign boundary and a duplicate pair
        offer_op(KIND_ADD, KEY_MAX);
        offer_op(KIND_ADD, KEY_MIN);
        offer_op(KIND_ADD, '0);
        idle_gap();
        offer_op(KIND_ADD, '1);
        offer_op(KIND_ADD, key_t'(1));
        offer_op(KIND_ADD, key_t'(5));
        offer_op(KIND_ADD, key_t'(5));

        // smallest two come out first: min then -1
        offer_op(KIND_POP, '0);
        offer_op(KIND_POP, KEY_MIN);

        // fill to the top, then an add that must be dropped
        for (int n = 0; n < DEPTH - 5; n++) begin
            offer_op(KIND_ADD, pick_key());
            idle_gap();
        end
        offer_op(KIND_ADD, '0);
        offer_op(KIND_POP, '1);
        drain_wait();

        // receiver holds off while the sender keeps offering: input stalls
        hold_req++;
        for (int n = 0; n < 10; n++)
            offer_op((n % 3 == 2) ? KIND_POP : KIND_ADD, pick_key());
        drain_wait();

        // random bursts, each leaning toward filling, mixing or emptying
        while (random_sent < RANDOM_OPS) begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: add_pct = 85;
                1: add_pct = 50;
                default: add_pct = 15;
            endcase
            if ($urandom_range(0, 9) == 0)
                hold_req++;
            for (int n = 0; n < burst_len; n++) begin
                kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_POP;
                offer_op(kind, pick_key());
                random_sent++;
                idle_gap();
            end
            if ($urandom_range(0, 7) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d adds (%0d dropped on full) and %0d pops (%0d on empty)",
                 sb.adds, sb.full_adds, sb.pops, sb.empty_pops);
        $display("%0d results checked, peak fill %0d of %0d, %0d mismatches",
                 sb.checked, sb.peak_fill, DEPTH, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
